// ===== sv/pts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pts_pkg;

    localparam int TASK_SLOTS_DEF      = 16;
    localparam int PRIORITY_LEVELS_DEF = 4;

    localparam logic [15:0] TIMESLICE_RESET = 16'd20;
    localparam logic [15:0] MIN_SLEEP       = 16'd2;

    localparam logic [2:0] OP_CREATE = 3'd0;
    localparam logic [2:0] OP_BLOCK  = 3'd1;
    localparam logic [2:0] OP_SLEEP  = 3'd2;
    localparam logic [2:0] OP_READY  = 3'd3;
    localparam logic [2:0] OP_TICK   = 3'd4;
    localparam logic [2:0] OP_SWITCH = 3'd5;
    localparam logic [2:0] OP_SCAN   = 3'd6;

    localparam logic [1:0] ST_WAITING = 2'd0;
    localparam logic [1:0] ST_READY   = 2'd1;
    localparam logic [1:0] ST_RUNNING = 2'd2;

    typedef struct packed {
        logic       status;
        logic [3:0] current_task;
        logic [3:0] result_task;
        logic       switch_request;
    } t_result;

    typedef struct packed {
        logic done;
        logic zero;
    } t_mod_sts;

endpackage

`default_nettype wire

// ===== sv/pts_mod.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring remainder unit: one dividend bit per cycle.
module pts_mod (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [31:0]       i_dividend,
    input  wire logic [15:0]       i_divisor,
    output pts_pkg::t_mod_sts      o_sts
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [15:0] r_rem;
    logic [31:0] r_dvd;
    logic [15:0] r_div;
    logic [16:0] trial;
    logic [16:0] diff;
    logic [15:0] n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[31]};
        diff  = trial - {1'b0, r_div};
        if (trial >= {1'b0, r_div}) begin
            n_rem = diff[15:0];
        end else begin
            n_rem = trial[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
                r_rem  <= 16'd0;
                r_dvd  <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= {r_dvd[30:0], 1'b0};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.done = r_done;
    assign o_sts.zero = (r_rem == 16'd0);

endmodule

`default_nettype wire

// ===== sv/pts_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pts_engine #(
    parameter int TASK_SLOTS      = pts_pkg::TASK_SLOTS_DEF,
    parameter int PRIORITY_LEVELS = pts_pkg::PRIORITY_LEVELS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [2:0]    i_opcode,
    input  wire logic [1:0]    i_prio,
    input  wire logic [3:0]    i_tid,
    input  wire logic [15:0]   i_dur,
    input  wire logic [15:0]   i_timeslice,
    input  wire logic          i_out_free,
    output logic               o_idle,
    output logic               o_res_valid,
    output pts_pkg::t_result   o_res
);

    localparam int TW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int LW = $clog2(TASK_SLOTS + 1);
    localparam int PW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
    localparam logic [LW-1:0] NIL = LW'(TASK_SLOTS);
    localparam logic [PW-1:0] TOP_LVL = PW'(PRIORITY_LEVELS - 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RDPRIO = 4'd1;
    localparam logic [3:0] S_WALK   = 4'd2;
    localparam logic [3:0] S_PUSH   = 4'd3;
    localparam logic [3:0] S_SCAN   = 4'd4;
    localparam logic [3:0] S_SW0    = 4'd5;
    localparam logic [3:0] S_SW1    = 4'd6;
    localparam logic [3:0] S_SWLV   = 4'd7;
    localparam logic [3:0] S_SWSET  = 4'd8;
    localparam logic [3:0] S_MOD    = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    // task table, one row per slot
    logic [1:0]    r_tb_state [TASK_SLOTS];
    logic [PW-1:0] r_tb_prio  [TASK_SLOTS];
    logic [LW-1:0] r_tb_link  [TASK_SLOTS];
    logic [31:0]   r_tb_wake  [TASK_SLOTS];

    logic [LW-1:0] r_rhead [PRIORITY_LEVELS];
    logic [LW-1:0] r_wait_head;
    logic [TW-1:0] r_run;
    logic [LW-1:0] r_count;
    logic [31:0]   r_tick;

    logic [3:0]    r_st;
    logic [TW-1:0] r_tgt;
    logic          r_list_wait;
    logic          r_is_scan;
    logic [PW-1:0] r_lvl;
    logic [LW-1:0] r_cur;
    logic [LW-1:0] r_prev;
    logic [LW-1:0] r_steps;
    logic [LW-1:0] r_nx;
    logic          r_nx_rdy;
    logic [PW-1:0] r_cur_prio;
    logic [LW-1:0] r_pick;
    logic          r_status;
    logic [TW-1:0] r_result;
    logic          r_sw;

    logic [TW-1:0] rd_addr;
    logic [1:0]    rd_state;
    logic [PW-1:0] rd_prio;
    logic [LW-1:0] rd_link;
    logic [31:0]   rd_wake;
    logic [PW-1:0] rh_addr;
    logic [LW-1:0] rh_q;
    logic [PW-1:0] p_sat;
    logic [TW+3:0] tid_ext;
    logic [TW+3:0] run_ext;
    logic [TW+3:0] res_ext;
    logic [31:0]   tick_inc;
    logic          mod_start;
    pts_pkg::t_mod_sts mod_sts;

    function automatic logic is_task(input logic [LW-1:0] v);
        return v < NIL;
    endfunction

    always_comb begin
        case (r_st)
            S_RDPRIO, S_PUSH: rd_addr = r_tgt;
            S_WALK, S_SCAN:   rd_addr = r_cur[TW-1:0];
            S_SW1:            rd_addr = r_nx[TW-1:0];
            default:          rd_addr = r_run;
        endcase
    end

    assign rd_state = r_tb_state[rd_addr];
    assign rd_prio  = r_tb_prio[rd_addr];
    assign rd_link  = r_tb_link[rd_addr];
    assign rd_wake  = r_tb_wake[rd_addr];

    always_comb begin
        if (32'(i_prio) >= PRIORITY_LEVELS) begin
            p_sat = TOP_LVL;
        end else begin
            p_sat = PW'(i_prio);
        end
    end

    always_comb begin
        case (r_st)
            S_IDLE:           rh_addr = p_sat;
            S_RDPRIO, S_PUSH: rh_addr = rd_prio;
            default:          rh_addr = r_lvl;
        endcase
    end

    assign rh_q     = r_rhead[rh_addr];
    assign tid_ext  = {{TW{1'b0}}, i_tid};
    assign tick_inc = r_tick + 32'd1;
    assign mod_start = (r_st == S_IDLE) && i_start && (i_opcode == pts_pkg::OP_TICK)
                       && (i_timeslice != 16'd0);

    pts_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (tick_inc),
        .i_divisor  (i_timeslice),
        .o_sts      (mod_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st          <= S_IDLE;
            r_tb_state[0] <= pts_pkg::ST_RUNNING;
            r_tb_prio[0]  <= '0;
            r_tb_link[0]  <= NIL;
            r_tb_wake[0]  <= 32'd0;
            for (int i = 0; i < PRIORITY_LEVELS; i++) begin
                r_rhead[i] <= NIL;
            end
            r_rhead[0]  <= '0;
            r_wait_head <= NIL;
            r_run       <= '0;
            r_count     <= LW'(1);
            r_tick      <= 32'd0;
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (i_start) begin
                        r_status  <= 1'b0;
                        r_result  <= '0;
                        r_sw      <= 1'b0;
                        r_is_scan <= 1'b0;
                        r_tgt     <= r_run;
                        r_st      <= S_DONE;
                        case (i_opcode)
                            pts_pkg::OP_CREATE: begin
                                if (r_count >= NIL) begin
                                    r_status <= 1'b1;
                                end else begin
                                    r_tb_state[r_count[TW-1:0]] <= pts_pkg::ST_READY;
                                    r_tb_wake[r_count[TW-1:0]]  <= 32'd0;
                                    r_tb_prio[r_count[TW-1:0]]  <= p_sat;
                                    r_tb_link[r_count[TW-1:0]]  <= rh_q;
                                    r_rhead[p_sat] <= r_count;
                                    r_count  <= r_count + LW'(1);
                                    r_result <= r_count[TW-1:0];
                                end
                            end
                            pts_pkg::OP_BLOCK: begin
                                r_sw <= 1'b1;
                                r_st <= S_RDPRIO;
                            end
                            pts_pkg::OP_SLEEP: begin
                                if (i_dur < pts_pkg::MIN_SLEEP) begin
                                    r_status <= 1'b1;
                                end else begin
                                    r_tb_wake[r_run] <= r_tick + {16'd0, i_dur};
                                    r_sw <= 1'b1;
                                    r_st <= S_RDPRIO;
                                end
                            end
                            pts_pkg::OP_READY: begin
                                if (tid_ext >= (TW+4)'(TASK_SLOTS)) begin
                                    r_status <= 1'b1;
                                end else begin
                                    r_tgt       <= tid_ext[TW-1:0];
                                    r_list_wait <= 1'b1;
                                    r_cur       <= r_wait_head;
                                    r_prev      <= NIL;
                                    r_steps     <= '0;
                                    r_st        <= S_WALK;
                                end
                            end
                            pts_pkg::OP_TICK: begin
                                r_tick <= tick_inc;
                                if (i_timeslice != 16'd0) begin
                                    r_st <= S_MOD;
                                end
                            end
                            pts_pkg::OP_SWITCH: begin
                                r_st <= S_SW0;
                            end
                            pts_pkg::OP_SCAN: begin
                                r_status  <= 1'b1;
                                r_is_scan <= 1'b1;
                                r_cur     <= r_wait_head;
                                r_steps   <= '0;
                                r_st      <= S_SCAN;
                            end
                            default: begin
                                r_status <= 1'b1;
                            end
                        endcase
                    end
                end
                S_RDPRIO: begin
                    r_lvl       <= rd_prio;
                    r_cur       <= rh_q;
                    r_prev      <= NIL;
                    r_steps     <= '0;
                    r_list_wait <= 1'b0;
                    r_st        <= S_WALK;
                end
                S_WALK: begin
                    if (r_steps < NIL && is_task(r_cur)) begin
                        if (r_cur == LW'(r_tgt)) begin
                            if (!is_task(r_prev)) begin
                                if (r_list_wait) begin
                                    r_wait_head <= rd_link;
                                end else begin
                                    r_rhead[r_lvl] <= rd_link;
                                end
                            end else begin
                                r_tb_link[r_prev[TW-1:0]] <= rd_link;
                            end
                            r_st <= S_PUSH;
                        end else begin
                            r_prev  <= r_cur;
                            r_cur   <= rd_link;
                            r_steps <= r_steps + LW'(1);
                        end
                    end else begin
                        r_status <= 1'b1;
                        r_st     <= S_DONE;
                    end
                end
                S_PUSH: begin
                    if (r_list_wait) begin
                        // leaving the waiting list: onto the ready list of its level
                        r_tb_link[r_tgt]  <= rh_q;
                        r_rhead[rd_prio]  <= LW'(r_tgt);
                        r_tb_state[r_tgt] <= pts_pkg::ST_READY;
                        if (!r_is_scan) begin
                            r_sw <= 1'b1;
                        end
                    end else begin
                        r_tb_link[r_tgt]  <= r_wait_head;
                        r_wait_head       <= LW'(r_tgt);
                        r_tb_state[r_tgt] <= pts_pkg::ST_WAITING;
                    end
                    r_st <= S_DONE;
                end
                S_SCAN: begin
                    if (r_steps < NIL && is_task(r_cur)) begin
                        if (rd_wake != 32'd0 && rd_wake < r_tick) begin
                            r_tb_wake[r_cur[TW-1:0]] <= 32'd0;
                            r_result    <= r_cur[TW-1:0];
                            r_status    <= 1'b0;
                            r_tgt       <= r_cur[TW-1:0];
                            r_list_wait <= 1'b1;
                            r_cur       <= r_wait_head;
                            r_prev      <= NIL;
                            r_steps     <= '0;
                            r_st        <= S_WALK;
                        end else begin
                            r_cur   <= rd_link;
                            r_steps <= r_steps + LW'(1);
                        end
                    end else begin
                        r_st <= S_DONE;
                    end
                end
                S_SW0: begin
                    if (rd_state == pts_pkg::ST_RUNNING) begin
                        r_tb_state[r_run] <= pts_pkg::ST_READY;
                    end
                    r_nx       <= rd_link;
                    r_cur_prio <= rd_prio;
                    r_pick     <= LW'(r_run);
                    r_lvl      <= TOP_LVL;
                    r_st       <= S_SW1;
                end
                S_SW1: begin
                    r_nx_rdy <= is_task(r_nx) && (rd_state == pts_pkg::ST_READY);
                    r_st     <= S_SWLV;
                end
                S_SWLV: begin
                    // one priority level per cycle, highest first
                    if (r_lvl == r_cur_prio && r_nx_rdy) begin
                        r_pick <= r_nx;
                        r_st   <= S_SWSET;
                    end else if (is_task(rh_q)) begin
                        r_pick <= rh_q;
                        r_st   <= S_SWSET;
                    end else if (r_lvl == '0) begin
                        r_st <= S_SWSET;
                    end else begin
                        r_lvl <= r_lvl - PW'(1);
                    end
                end
                S_SWSET: begin
                    r_tb_state[r_pick[TW-1:0]] <= pts_pkg::ST_RUNNING;
                    r_run <= r_pick[TW-1:0];
                    r_st  <= S_DONE;
                end
                S_MOD: begin
                    if (mod_sts.done) begin
                        r_sw <= mod_sts.zero;
                        r_st <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_out_free) begin
                        r_st <= S_IDLE;
                    end
                end
                default: begin
                    r_st <= S_IDLE;
                end
            endcase
        end
    end

    assign run_ext = {4'd0, r_run};
    assign res_ext = {4'd0, r_result};

    assign o_idle      = (r_st == S_IDLE);
    assign o_res_valid = (r_st == S_DONE);
    assign o_res.status         = r_status;
    assign o_res.current_task   = run_ext[3:0];
    assign o_res.result_task    = res_ext[3:0];
    assign o_res.switch_request = r_sw;

endmodule

`default_nettype wire

// ===== sv/priority_task_scheduler.sv =====
// Priority task scheduler with per-level ready lists and a waiting list.
// Input stream: one command item per handshake on the s_ side. tuser holds
// the opcode, tdata the priority, task id and sleep duration. Output stream:
// one result item per command on the m_ side (status, running task, created
// or woken task, switch request).
// The config port writes the timeslice (ticks between switch requests); it is
// to be written only while no command is in flight, and the block itself
// does not enforce this. Create, unknown opcodes and short sleeps go straight
// to the result; block, sleep and make-ready walk the affected list one link
// per cycle; scan walks the waiting list and then the removal walk; switch
// steps through the priority levels, highest first; tick runs the remainder
// unit when the timeslice is nonzero. The table has a single read port, so
// list walks advance one entry per cycle.
// One command is in flight at a time; s_tready is high while the sequencer is
// idle. A finished result sits in the output register; while the receiver
// stalls the sequencer holds the next result and takes no new command.
// Reset: task 0 runs at priority 0, tick count 0, timeslice 20, no pending item.
`timescale 1ns / 1ps
`default_nettype none

module priority_task_scheduler #(
    parameter int TASK_SLOTS      = pts_pkg::TASK_SLOTS_DEF,
    parameter int PRIORITY_LEVELS = pts_pkg::PRIORITY_LEVELS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,   // priority_req[1:0], task_id[5:2], duration[21:6]
    input  wire logic [2:0]  i_s_tuser,   // opcode[2:0]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,   // status[0], current_task[4:1],
                                          // result_task[8:5], switch_request[9]
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata
);

    logic [15:0]       r_timeslice;
    logic              r_ovalid;
    logic [15:0]       r_odata;
    logic              eng_idle;
    logic              eng_valid;
    logic              out_free;
    pts_pkg::t_result  eng_res;

    assign out_free = !r_ovalid || i_m_tready;

    pts_engine #(
        .TASK_SLOTS      (TASK_SLOTS),
        .PRIORITY_LEVELS (PRIORITY_LEVELS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_s_tvalid),
        .i_opcode    (i_s_tuser),
        .i_prio      (i_s_tdata[1:0]),
        .i_tid       (i_s_tdata[5:2]),
        .i_dur       (i_s_tdata[21:6]),
        .i_timeslice (r_timeslice),
        .i_out_free  (out_free),
        .o_idle      (eng_idle),
        .o_res_valid (eng_valid),
        .o_res       (eng_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeslice <= pts_pkg::TIMESLICE_RESET;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_timeslice <= i_cfg_wdata;
            end
            if (eng_valid && out_free) begin
                r_ovalid <= 1'b1;
                r_odata  <= {6'd0, eng_res.switch_request, eng_res.result_task,
                             eng_res.current_task, eng_res.status};
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_s_tready = eng_idle;
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("scheduler ready right after taking an item");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_valid && !out_free |=> eng_valid)
        else $error("finished result dropped while output stalled");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(eng_valid))
        else $error("output item without a finished result");

endmodule

`default_nettype wire

// ===== bench/pts_checker.sv =====
`timescale 1ns / 1ps

module pts_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,
    input  logic [2:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);

    localparam int NSLOT = pts_pkg::TASK_SLOTS_DEF;
    localparam int NLVL  = pts_pkg::PRIORITY_LEVELS_DEF;
    localparam logic [4:0] NIL = 5'(NSLOT);

    logic [1:0]  run_st [NSLOT];
    logic [1:0]  prio_of [NSLOT];
    logic [4:0]  link_of [NSLOT];
    logic [31:0] wake_at [NSLOT];
    logic [4:0]  rdy_head [NLVL];
    logic [4:0]  wait_head;
    logic [3:0]  running;
    logic [4:0]  n_tasks;
    logic [31:0] ticks;
    logic [15:0] slice;

    pts_pkg::t_result sched_expect_q[$];

    // unlink tsk from a list; lvl -1 selects the waiting list
    function automatic logic unlink_task(input int lvl, input logic [4:0] tsk);
        logic [4:0] cur, prv;
        cur = (lvl < 0) ? wait_head : rdy_head[lvl];
        prv = NIL;
        for (int s = 0; s < NSLOT && cur < NIL; s++) begin
            if (cur == tsk) begin
                if (prv == NIL) begin
                    if (lvl < 0) wait_head = link_of[cur[3:0]];
                    else rdy_head[lvl] = link_of[cur[3:0]];
                end else begin
                    link_of[prv[3:0]] = link_of[cur[3:0]];
                end
                return 1'b1;
            end
            prv = cur;
            cur = link_of[cur[3:0]];
        end
        return 1'b0;
    endfunction

    function automatic logic park_task(input logic [3:0] tsk);
        if (!unlink_task(int'(prio_of[tsk]), {1'b0, tsk})) return 1'b0;
        link_of[tsk] = wait_head;
        wait_head = {1'b0, tsk};
        run_st[tsk] = pts_pkg::ST_WAITING;
        return 1'b1;
    endfunction

    function automatic logic wake_task(input logic [3:0] tsk);
        if (!unlink_task(-1, {1'b0, tsk})) return 1'b0;
        link_of[tsk] = rdy_head[prio_of[tsk]];
        rdy_head[prio_of[tsk]] = {1'b0, tsk};
        run_st[tsk] = pts_pkg::ST_READY;
        return 1'b1;
    endfunction

    function automatic logic [3:0] choose_next(input logic [3:0] cur);
        logic [4:0] nx;
        for (int l = NLVL - 1; l >= 0; l--) begin
            nx = link_of[cur];
            if (l == int'(prio_of[cur]) && nx < NIL &&
                run_st[nx[3:0]] == pts_pkg::ST_READY)
                return nx[3:0];
            if (rdy_head[l] < NIL) return rdy_head[l][3:0];
        end
        return cur;
    endfunction

    function automatic pts_pkg::t_result schedule_cmd(input logic [2:0] op,
                                                      input logic [23:0] d);
        pts_pkg::t_result r;
        logic [1:0]  pr;
        logic [3:0]  tid, cur;
        logic [15:0] dur;
        logic [4:0]  t;
        pr  = d[1:0];
        tid = d[5:2];
        dur = d[21:6];
        cur = running;
        r = '0;
        case (op)
            pts_pkg::OP_CREATE: begin
                if (n_tasks >= 5'(NSLOT)) begin
                    r.status = 1'b1;
                end else begin
                    t = n_tasks;
                    n_tasks++;
                    run_st[t[3:0]] = pts_pkg::ST_READY;
                    wake_at[t[3:0]] = '0;
                    prio_of[t[3:0]] = pr;
                    link_of[t[3:0]] = rdy_head[pr];
                    rdy_head[pr] = t;
                    r.result_task = t[3:0];
                end
            end
            pts_pkg::OP_BLOCK: begin
                r.status = !park_task(cur);
                r.switch_request = 1'b1;
            end
            pts_pkg::OP_SLEEP: begin
                if (dur < pts_pkg::MIN_SLEEP) begin
                    r.status = 1'b1;
                end else begin
                    wake_at[cur] = ticks + 32'(dur);
                    r.status = !park_task(cur);
                    r.switch_request = 1'b1;
                end
            end
            pts_pkg::OP_READY: begin
                if (wake_task(tid)) r.switch_request = 1'b1;
                else r.status = 1'b1;
            end
            pts_pkg::OP_TICK: begin
                ticks++;
                if (slice != 0 && (ticks % 32'(slice)) == 0) r.switch_request = 1'b1;
            end
            pts_pkg::OP_SWITCH: begin
                if (run_st[cur] == pts_pkg::ST_RUNNING) run_st[cur] = pts_pkg::ST_READY;
                cur = choose_next(cur);
                run_st[cur] = pts_pkg::ST_RUNNING;
                running = cur;
            end
            pts_pkg::OP_SCAN: begin
                r.status = 1'b1;
                t = wait_head;
                for (int s = 0; s < NSLOT && t < NIL; s++) begin
                    if (wake_at[t[3:0]] != 0 && wake_at[t[3:0]] < ticks) begin
                        wake_at[t[3:0]] = '0;
                        void'(wake_task(t[3:0]));
                        r.result_task = t[3:0];
                        r.status = 1'b0;
                        break;
                    end
                    t = link_of[t[3:0]];
                end
            end
            default: r.status = 1'b1;
        endcase
        r.current_task = running;
        return r;
    endfunction

    pts_pkg::t_result got;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NSLOT; i++) begin
                run_st[i] = pts_pkg::ST_WAITING;
                prio_of[i] = '0;
                link_of[i] = NIL;
                wake_at[i] = '0;
            end
            for (int l = 0; l < NLVL; l++) rdy_head[l] = NIL;
            run_st[0] = pts_pkg::ST_RUNNING;
            rdy_head[0] = '0;
            wait_head = NIL;
            running = '0;
            n_tasks = 5'd1;
            ticks = '0;
            slice = pts_pkg::TIMESLICE_RESET;
            sched_expect_q.delete();
            o_errors <= 0;
            o_results <= 0;
        end else begin
            if (i_cfg_we) slice = i_cfg_wdata;
            if (i_m_tvalid && i_m_tready) begin
                got = pts_pkg::t_result'({i_m_tdata[0], i_m_tdata[4:1], i_m_tdata[8:5],
                                          i_m_tdata[9]});
                o_results <= o_results + 1;
                if (sched_expect_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    pts_pkg::t_result e;
                    e = sched_expect_q.pop_front();
                    if (e != got || i_m_tdata[15:10] != 0) begin
                        $display("%0t: result mismatch exp sts=%0b cur=%0d res=%0d sw=%0b",
                                 $time, e.status, e.current_task, e.result_task,
                                 e.switch_request);
                        $display("%0t:                 got sts=%0b cur=%0d res=%0d sw=%0b",
                                 $time, got.status, got.current_task, got.result_task,
                                 got.switch_request);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                sched_expect_q.push_back(schedule_cmd(i_s_tuser, i_s_tdata));
        end
        o_pending <= sched_expect_q.size();
    end
endmodule

// ===== bench/tb_priority_task_scheduler.sv =====
`timescale 1ns / 1ps

module tb_priority_task_scheduler;

    localparam int CYCLE_LIMIT = 600000;
    localparam logic [2:0] OP_UNUSED = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    int          errors, pending, results;
    int          cycles = 0;
    int          send_idle = 0;
    int          recv_idle = 0;
    int          hold_off = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    priority_task_scheduler i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata)
    );

    pts_checker i_chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off when requested
    always @(negedge clk) begin
        if (hold_off > 0) begin
            m_tready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // called at a falling edge; returns at the falling edge after the accept,
    // with tvalid still high so the next item can follow at once
    task automatic send_cmd(input logic [2:0] op, input logic [1:0] pr,
                            input logic [3:0] tid, input logic [15:0] dur);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, dur, tid, pr};
        // tready only moves at rising edges, so it is stable here
        while (!s_tready) @(negedge clk);
        @(negedge clk);
    endtask

    task automatic drain_and_config(input logic [15:0] val);
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (80) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_cmd();
        int pick;
        logic [15:0] dur;
        pick = $urandom_range(99);
        dur = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(40));
        if (pick < 10)
            send_cmd(pts_pkg::OP_CREATE, 2'($urandom), 4'($urandom), 16'($urandom));
        else if (pick < 20)
            send_cmd(pts_pkg::OP_BLOCK, 2'($urandom), 4'($urandom), 16'($urandom));
        else if (pick < 32)
            send_cmd(pts_pkg::OP_SLEEP, 2'($urandom), 4'($urandom), dur);
        else if (pick < 44)
            send_cmd(pts_pkg::OP_READY, 2'($urandom), 4'($urandom), 16'($urandom));
        else if (pick < 66)
            send_cmd(pts_pkg::OP_TICK, 2'($urandom), 4'($urandom), 16'($urandom));
        else if (pick < 82)
            send_cmd(pts_pkg::OP_SWITCH, 2'($urandom), 4'($urandom), 16'($urandom));
        else if (pick < 97)
            send_cmd(pts_pkg::OP_SCAN, 2'($urandom), 4'($urandom), 16'($urandom));
        else
            send_cmd(OP_UNUSED, 2'($urandom), 4'($urandom), 16'($urandom));
    endtask

    initial begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        drain_and_config(16'd3);

        // directed: extremes, every opcode, corner cases
        send_cmd(pts_pkg::OP_SWITCH, 2'd0, 4'd0, 16'd0);
        send_cmd(pts_pkg::OP_SCAN, 2'd0, 4'd0, 16'd0);      // nothing waiting
        send_cmd(pts_pkg::OP_READY, 2'd0, 4'd15, 16'd0);    // not in waiting list
        send_cmd(pts_pkg::OP_SLEEP, 2'd0, 4'd0, 16'd1);     // too short
        send_cmd(pts_pkg::OP_SLEEP, 2'd0, 4'd0, 16'd0);
        send_cmd(pts_pkg::OP_CREATE, 2'd3, 4'd0, 16'd0);
        send_cmd(pts_pkg::OP_CREATE, 2'd0, 4'd0, 16'd0);
        send_cmd(pts_pkg::OP_BLOCK, 2'd0, 4'd0, 16'd0);     // task 0 waits
        send_cmd(pts_pkg::OP_BLOCK, 2'd0, 4'd0, 16'd0);     // already waiting: fail
        send_cmd(pts_pkg::OP_SWITCH, 2'd0, 4'd0, 16'd0);
        send_cmd(pts_pkg::OP_SLEEP, 2'd0, 4'd0, 16'd2);
        repeat (4) send_cmd(pts_pkg::OP_TICK, 2'd0, 4'd0, 16'd0);
        send_cmd(pts_pkg::OP_SCAN, 2'd0, 4'd0, 16'd0);      // wakes the sleeper
        send_cmd(pts_pkg::OP_READY, 2'd0, 4'd0, 16'hffff);
        send_cmd(pts_pkg::OP_SWITCH, 2'd0, 4'd0, 16'd0);
        send_cmd(pts_pkg::OP_SLEEP, 2'd3, 4'd15, 16'hffff);
        send_cmd(OP_UNUSED, 2'd3, 4'd15, 16'hffff);
        send_cmd(pts_pkg::OP_SWITCH, 2'd0, 4'd0, 16'd0);

        drain_and_config(16'd1);
        send_idle = 23; recv_idle = 55;
        for (int i = 0; i < 200; i++) random_cmd();

        drain_and_config(16'hffff);
        send_idle = 55; recv_idle = 23;
        for (int i = 0; i < 200; i++) random_cmd();

        drain_and_config(16'd0);
        send_idle = 0; recv_idle = 0;
        hold_off = 300;   // receiver blocks while items keep coming
        for (int i = 0; i < 100; i++) random_cmd();

        drain_and_config(16'd7);
        for (int i = 0; i < 130; i++) random_cmd();

        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        $display("covered all opcodes, 5 timeslice settings (0, 1, 3, 7, 65535)");
        $display("results checked: %0d, stall phases incl. long receiver hold-off",
                 results);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
